// File: design/nebs_pkg.sv
// Shared types and constants for the nearest-entry binary search block.
// No dependencies; used by every module in this folder.
`default_nettype none

package nebs_pkg;

	// Table geometry
	localparam int MAX_ENTRIES = 256;
	localparam int ADDR_W      = $clog2(MAX_ENTRIES);

	// Field widths fixed by the interface
	localparam int FREQ_W  = 32;
	localparam int INDEX_W = 8;
	localparam int CNT_W   = 9;

	// Shared subtractor works on signed values wide enough for a difference of distances
	localparam int OP_W = FREQ_W + 2;

	// Operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_LAST,
		ST_PROBE,
		ST_DLO,
		ST_DHI,
		ST_PICK,
		ST_OUT
	} state_t;

	// Status flags of the shared subtractor
	typedef struct packed {
		logic neg;
		logic zero;
	} sub_flags_t;

endpackage

`default_nettype wire

// File: design/nearest_entry_binary_search.sv
// Nearest-entry binary search: a write transfer gives no result. A query reads the first
// and last entries, makes P midpoint probes (at most ceil(log2(count-1)), 8 for 256
// entries), then forms both distances and picks; an edge hit or an exact match at a
// midpoint ends it early. The next item is taken in the cycle after the result transfer.
// The table read port and the shared subtractor set the pace of the search.
// Reset clears the sequencer and sets entry_count to 1; table contents stay undefined.
`default_nettype none

module nearest_entry_binary_search (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                operation,
	input  wire logic [7:0]                          entry_index,
	input  wire logic [nebs_pkg::FREQ_W-1:0]         freq_value,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [nebs_pkg::INDEX_W-1:0]             nearest_index,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [nebs_pkg::CNT_W-1:0]          cfg_data
);

	logic [nebs_pkg::CNT_W-1:0]  entry_count_q;
	logic                        wr_en;
	logic [nebs_pkg::ADDR_W-1:0] rd_addr;
	logic [nebs_pkg::FREQ_W-1:0] rd_data;

	assign cfg_ready = 1'b1;

	// Hold the entry count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= nebs_pkg::CNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			entry_count_q <= cfg_data;
		end
	end

	// Write a table entry on a write transfer; drop indexes beyond the table
	assign wr_en = in_valid && !in_stall && (operation == nebs_pkg::OP_WRITE)
		&& (32'(entry_index) < nebs_pkg::MAX_ENTRIES);

	nebs_mem u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (nebs_pkg::ADDR_W'(entry_index)),
		.wr_data (freq_value),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	nebs_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.operation     (operation),
		.freq_value    (freq_value),
		.entry_count   (entry_count_q),
		.in_stall      (in_stall),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.nearest_index (nearest_index)
	);

endmodule

`default_nettype wire

// File: design/nebs_mem.sv
// Frequency table storage: one write port, one registered read port.
// Depends on nebs_pkg for widths and depth.
`default_nettype none

module nebs_mem (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [nebs_pkg::ADDR_W-1:0] wr_addr,
	input  wire logic [nebs_pkg::FREQ_W-1:0] wr_data,
	input  wire logic [nebs_pkg::ADDR_W-1:0] rd_addr,
	output logic      [nebs_pkg::FREQ_W-1:0] rd_data
);

	logic [nebs_pkg::FREQ_W-1:0] mem [nebs_pkg::MAX_ENTRIES];

	// Write one entry per transfer
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read every cycle, data available in the cycle after the address
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// File: design/nebs_sub.sv
// Shared signed subtractor used for every compare and distance of the search.
// Depends on nebs_pkg for the operand width and flag struct.
`default_nettype none

module nebs_sub (
	input  wire logic signed [nebs_pkg::OP_W-1:0] a,
	input  wire logic signed [nebs_pkg::OP_W-1:0] b,
	output logic signed      [nebs_pkg::OP_W-1:0] diff,
	output nebs_pkg::sub_flags_t                  flags
);

	// Subtract and derive sign and zero
	always_comb begin
		diff       = a - b;
		flags.neg  = diff[nebs_pkg::OP_W-1];
		flags.zero = (diff == '0);
	end

endmodule

`default_nettype wire

// File: design/nebs_ctrl.sv
// Search sequencer: holds the bounds, drives the table read port and the shared
// subtractor, and registers the result. Depends on nebs_pkg and nebs_sub.
`default_nettype none

module nebs_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic                         operation,
	input  wire logic [nebs_pkg::FREQ_W-1:0]  freq_value,
	input  wire logic [nebs_pkg::CNT_W-1:0]   entry_count,
	output logic                              in_stall,
	output logic [nebs_pkg::ADDR_W-1:0]       rd_addr,
	input  wire logic [nebs_pkg::FREQ_W-1:0]  rd_data,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [nebs_pkg::INDEX_W-1:0]      nearest_index
);

	localparam int AW = nebs_pkg::ADDR_W;
	localparam int OW = nebs_pkg::OP_W;
	localparam int FW = nebs_pkg::FREQ_W;

	nebs_pkg::state_t state_q, state_nx;

	logic [FW-1:0]        f_q;
	logic [FW-1:0]        vlo_q;
	logic [FW-1:0]        vhi_q;
	logic [AW-1:0]        lo_q;
	logic [AW-1:0]        hi_q;
	logic [AW-1:0]        mid_q;
	logic [AW-1:0]        res_q;
	logic signed [OW-1:0] dlo_q;
	logic signed [OW-1:0] dhi_q;

	logic                 query_go;
	logic [AW-1:0]        hi_init;
	logic [AW-1:0]        mid_first;
	logic [AW-1:0]        nlo;
	logic [AW-1:0]        nhi;
	logic [AW-1:0]        nmid;
	logic                 span_gt1;
	logic                 nspan_gt1;
	logic [AW:0]          sum_first;
	logic [AW:0]          sum_next;

	logic signed [OW-1:0] sub_a;
	logic signed [OW-1:0] sub_b;
	logic signed [OW-1:0] sub_diff;
	nebs_pkg::sub_flags_t sub_flags;

	nebs_sub u_sub (
		.a     (sub_a),
		.b     (sub_b),
		.diff  (sub_diff),
		.flags (sub_flags)
	);

	assign query_go = in_valid && !in_stall && (operation == nebs_pkg::OP_QUERY);

	// Clamp the entry count to the table size, zero counts as one
	always_comb begin
		if (entry_count == '0) begin
			hi_init = '0;
		end else if (32'(entry_count) > nebs_pkg::MAX_ENTRIES) begin
			hi_init = AW'(nebs_pkg::MAX_ENTRIES - 1);
		end else begin
			hi_init = AW'(entry_count - 1'b1);
		end
	end

	// Midpoints and narrowed bounds for the probe step
	always_comb begin
		sum_first = {1'b0, lo_q} + {1'b0, hi_q};
		mid_first = sum_first[AW:1];
		span_gt1  = (hi_q - lo_q) > AW'(1);
		nlo       = lo_q;
		nhi       = hi_q;
		if (sub_flags.neg) begin
			nhi = mid_q;
		end else begin
			nlo = mid_q;
		end
		sum_next  = {1'b0, nlo} + {1'b0, nhi};
		nmid      = sum_next[AW:1];
		nspan_gt1 = (nhi - nlo) > AW'(1);
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			nebs_pkg::ST_IDLE: begin
				if (query_go) begin
					state_nx = nebs_pkg::ST_FIRST;
				end
			end
			nebs_pkg::ST_FIRST: begin
				state_nx = sub_flags.neg ? nebs_pkg::ST_OUT : nebs_pkg::ST_LAST;
			end
			nebs_pkg::ST_LAST: begin
				if (!sub_flags.neg && !sub_flags.zero) begin
					state_nx = nebs_pkg::ST_OUT;
				end else if (span_gt1) begin
					state_nx = nebs_pkg::ST_PROBE;
				end else begin
					state_nx = nebs_pkg::ST_DLO;
				end
			end
			nebs_pkg::ST_PROBE: begin
				if (sub_flags.zero) begin
					state_nx = nebs_pkg::ST_OUT;
				end else if (nspan_gt1) begin
					state_nx = nebs_pkg::ST_PROBE;
				end else begin
					state_nx = nebs_pkg::ST_DLO;
				end
			end
			nebs_pkg::ST_DLO:  state_nx = nebs_pkg::ST_DHI;
			nebs_pkg::ST_DHI:  state_nx = nebs_pkg::ST_PICK;
			nebs_pkg::ST_PICK: state_nx = nebs_pkg::ST_OUT;
			nebs_pkg::ST_OUT: begin
				if (!out_stall) begin
					state_nx = nebs_pkg::ST_IDLE;
				end
			end
			default: state_nx = nebs_pkg::ST_IDLE;
		endcase
	end

	// Outputs: handshake, read address and subtractor operands
	always_comb begin
		in_stall  = (state_q != nebs_pkg::ST_IDLE);
		out_valid = (state_q == nebs_pkg::ST_OUT);
		rd_addr   = '0;
		sub_a     = $signed({{(OW-FW){1'b0}}, f_q});
		sub_b     = $signed({{(OW-FW){1'b0}}, rd_data});
		unique case (state_q)
			nebs_pkg::ST_IDLE:  rd_addr = '0;
			nebs_pkg::ST_FIRST: rd_addr = hi_q;
			nebs_pkg::ST_LAST:  rd_addr = mid_first;
			nebs_pkg::ST_PROBE: rd_addr = nmid;
			nebs_pkg::ST_DLO: begin
				sub_b = $signed({{(OW-FW){1'b0}}, vlo_q});
			end
			nebs_pkg::ST_DHI: begin
				sub_a = $signed({{(OW-FW){1'b0}}, vhi_q});
				sub_b = $signed({{(OW-FW){1'b0}}, f_q});
			end
			nebs_pkg::ST_PICK: begin
				sub_a = dlo_q;
				sub_b = dhi_q;
			end
			nebs_pkg::ST_OUT: rd_addr = '0;
			default:          rd_addr = '0;
		endcase
	end

	assign nearest_index = nebs_pkg::INDEX_W'(res_q);

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nebs_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Search datapath: bounds, bound values, distances, result
	always_ff @(posedge clk) begin
		case (state_q)
			nebs_pkg::ST_IDLE: begin
				if (query_go) begin
					f_q  <= freq_value;
					lo_q <= '0;
					hi_q <= hi_init;
				end
			end
			nebs_pkg::ST_FIRST: begin
				vlo_q <= rd_data;
				res_q <= '0;
			end
			nebs_pkg::ST_LAST: begin
				vhi_q <= rd_data;
				res_q <= hi_q;
				mid_q <= mid_first;
			end
			nebs_pkg::ST_PROBE: begin
				lo_q  <= nlo;
				hi_q  <= nhi;
				res_q <= mid_q;
				mid_q <= nmid;
				if (sub_flags.neg) begin
					vhi_q <= rd_data;
				end else begin
					vlo_q <= rd_data;
				end
			end
			nebs_pkg::ST_DLO: dlo_q <= sub_diff;
			nebs_pkg::ST_DHI: dhi_q <= sub_diff;
			nebs_pkg::ST_PICK: begin
				// lower neighbor wins only when strictly closer
				res_q <= sub_flags.neg ? lo_q : hi_q;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// File: verif/nearest_entry_binary_search_tb.sv
// Testbench for nearest_entry_binary_search: table writes, entry-count changes and queries,
// each query result checked against a fixed expected index or a nearest-entry predictor kept inside this bench.
// Depends on design/nebs_pkg.sv and design/nearest_entry_binary_search.sv.
`timescale 1ns / 100ps

module nearest_entry_binary_search_tb;

	// Directed stimulus rows: a count row carries the new entry_count in freq[8:0]
	typedef enum logic {ROW_ITEM, ROW_COUNT} row_kind_t;

	typedef struct packed {
		row_kind_t                    kind;
		logic                         op;
		logic [7:0]                   idx;
		logic [nebs_pkg::FREQ_W-1:0]  freq;
		logic                         known;
		logic [nebs_pkg::INDEX_W-1:0] nearest;
	} dir_row_t;

	localparam int DIR_ROWS = 20;
	localparam int IDLE_PCT = 12;

	logic                         clk;
	logic                         arst_n      = 1'b0;
	logic                         in_valid    = 1'b0;
	logic                         in_stall;
	logic                         operation   = nebs_pkg::OP_WRITE;
	logic [7:0]                   entry_index = '0;
	logic [nebs_pkg::FREQ_W-1:0]  freq_value  = '0;
	logic                         out_valid;
	logic                         out_stall   = 1'b0;
	logic [nebs_pkg::INDEX_W-1:0] nearest_index;
	logic                         cfg_valid   = 1'b0;
	logic                         cfg_ready;
	logic [nebs_pkg::CNT_W-1:0]   cfg_data    = '0;

	// Predictor copy of the block state
	logic [nebs_pkg::FREQ_W-1:0]  freq_copy [nebs_pkg::MAX_ENTRIES];
	logic [nebs_pkg::CNT_W-1:0]   count_copy;

	logic [nebs_pkg::INDEX_W-1:0] nearest_expected [$];
	dir_row_t                     dir_rows [DIR_ROWS];
	int                           fail_count = 0;
	int                           item_total = 0;
	bit                           quiet      = 1'b0;

	nearest_entry_binary_search uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.entry_index   (entry_index),
		.freq_value    (freq_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.nearest_index (nearest_index),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop for a hung run
	initial begin
		#500000;
		$display("** nearest_entry_binary_search: FAILED **");
		$finish;
	end

	task automatic report_mismatch(string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		fail_count++;
	endtask

	function automatic int searched_entries();
		int n;
		n = int'(count_copy);
		if (n == 0)
			n = 1;
		if (n > nebs_pkg::MAX_ENTRIES)
			n = nebs_pkg::MAX_ENTRIES;
		return n;
	endfunction

	// Binary search over the active entries; a tie goes to the upper neighbor
	function automatic logic [nebs_pkg::INDEX_W-1:0] predict_nearest(
			logic [nebs_pkg::FREQ_W-1:0] f);
		int     lo;
		int     hi;
		int     mid;
		longint d_lo;
		longint d_hi;
		lo = 0;
		hi = searched_entries() - 1;
		if (f < freq_copy[lo])
			return nebs_pkg::INDEX_W'(lo);
		if (f > freq_copy[hi])
			return nebs_pkg::INDEX_W'(hi);
		while (hi - lo > 1) begin
			mid = (lo + hi) >> 1;
			if (f < freq_copy[mid])
				hi = mid;
			else if (f > freq_copy[mid])
				lo = mid;
			else
				return nebs_pkg::INDEX_W'(mid);
		end
		d_lo = longint'(f) - longint'(freq_copy[lo]);
		d_hi = longint'(freq_copy[hi]) - longint'(f);
		return (d_lo < d_hi) ? nebs_pkg::INDEX_W'(lo) : nebs_pkg::INDEX_W'(hi);
	endfunction

	// Drive one input transfer; valid stays high on return so the next call may chain
	task automatic send_item(logic op, logic [7:0] idx, logic [nebs_pkg::FREQ_W-1:0] f,
			bit known, logic [nebs_pkg::INDEX_W-1:0] nearest);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= op;
		entry_index <= idx;
		freq_value  <= f;
		do @(posedge clk); while (in_stall);
		item_total++;
		if (op == nebs_pkg::OP_WRITE)
			freq_copy[idx] = f;
		else
			nearest_expected.push_back(known ? nearest : predict_nearest(f));
	endtask

	// Hold the sender until every result is back
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (nearest_expected.size() != 0);
	endtask

	// Change entry_count with the block idle
	task automatic set_entry_count(logic [nebs_pkg::CNT_W-1:0] value);
		wait_for_results();
		repeat (16) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		count_copy = value;
	endtask

	// One phase: set the count, optionally refill the table and add stray writes, then query it
	task automatic run_phase(logic [nebs_pkg::CNT_W-1:0] count, bit refill, bit noisy,
			int queries);
		int                          n;
		int                          k;
		int unsigned                 span;
		longint                      level;
		longint                      sum;
		logic [nebs_pkg::FREQ_W-1:0] f;
		set_entry_count(count);
		n = searched_entries();
		if (refill) begin
			span  = ($urandom_range(3) == 0) ? 16 : 32'hFFFF_FFFF / (n + 1);
			level = longint'($urandom_range(span));
			for (int i = 0; i < n; i++) begin
				if (noisy) begin
					f = $urandom;
				end else begin
					f = (level > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : level[31:0];
					level += ($urandom_range(7) == 0) ? 0 : longint'($urandom_range(span, 1));
				end
				send_item(nebs_pkg::OP_WRITE, 8'(i), f, 1'b0, '0);
			end
		end
		// Stray writes: past the active range when well-formed, anywhere when noisy
		if (noisy || n < nebs_pkg::MAX_ENTRIES) begin
			repeat ($urandom_range(3)) begin
				k = noisy ? $urandom_range(nebs_pkg::MAX_ENTRIES - 1)
					: $urandom_range(nebs_pkg::MAX_ENTRIES - 1, n);
				send_item(nebs_pkg::OP_WRITE, 8'(k), $urandom, 1'b0, '0);
			end
		end
		repeat (queries) begin
			k = $urandom_range(n - 1);
			case ($urandom_range(9)) inside
				[0:3]: f = freq_copy[k];
				4: f = freq_copy[k] + 1;
				5: f = freq_copy[k] - 1;
				[6:7]: begin
					if (k + 1 < n) begin
						sum = longint'(freq_copy[k]) + longint'(freq_copy[k + 1]);
						f   = nebs_pkg::FREQ_W'((sum >> 1) + $urandom_range(1));
					end else begin
						f = $urandom;
					end
				end
				8: f = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
				default: f = $urandom;
			endcase
			send_item(nebs_pkg::OP_QUERY, 8'($urandom), f, 1'b0, '0);
			if ($urandom_range(39) == 0)
				wait_for_results();
		end
	endtask

	// Result side: check each transfer, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (nearest_expected.size() == 0) begin
				report_mismatch($sformatf("unexpected result nearest_index=%0d", nearest_index));
			end else begin
				if (nearest_index !== nearest_expected[0])
					report_mismatch($sformatf("nearest_index got %0d expected %0d",
						nearest_index, nearest_expected[0]));
				void'(nearest_expected.pop_front());
			end
		end
		out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
	end

	initial begin
		int phase;
		for (int i = 0; i < nebs_pkg::MAX_ENTRIES; i++)
			freq_copy[i] = '0;
		count_copy = nebs_pkg::CNT_W'(1);

		dir_rows = '{
			'{ROW_ITEM,  nebs_pkg::OP_WRITE, 8'd0,   32'h0000_1000, 1'b0, 8'd0},
			'{ROW_ITEM,  nebs_pkg::OP_QUERY, 8'd0,   32'h0000_0000, 1'b1, 8'd0},
			'{ROW_ITEM,  nebs_pkg::OP_QUERY, 8'd0,   32'hFFFF_FFFF, 1'b1, 8'd0},
			'{ROW_ITEM,  nebs_pkg::OP_QUERY, 8'd0,   32'h0000_1000, 1'b1, 8'd0},
			'{ROW_ITEM,  nebs_pkg::OP_WRITE, 8'd1,   32'h0000_2000, 1'b0, 8'd0},
			'{ROW_ITEM,  nebs_pkg::OP_WRITE, 8'd2,   32'h0000_3000, 1'b0, 8'd0},
			'{ROW_ITEM,  nebs_pkg::OP_WRITE, 8'd3,   32'h0000_4000, 1'b0, 8'd0},
			'{ROW_COUNT, nebs_pkg::OP_WRITE, 8'd0,   32'd4,         1'b0, 8'd0},
			// equal distance to both neighbors: upper wins
			'{ROW_ITEM,  nebs_pkg::OP_QUERY, 8'd0,   32'h0000_1800, 1'b1, 8'd1},
			'{ROW_ITEM,  nebs_pkg::OP_QUERY, 8'd0,   32'h0000_17FF, 1'b1, 8'd0},
			'{ROW_ITEM,  nebs_pkg::OP_QUERY, 8'd0,   32'h0000_2000, 1'b1, 8'd1},
			'{ROW_ITEM,  nebs_pkg::OP_QUERY, 8'd0,   32'h0000_3000, 1'b1, 8'd2},
			'{ROW_ITEM,  nebs_pkg::OP_QUERY, 8'd0,   32'h0000_4000, 1'b1, 8'd3},
			'{ROW_ITEM,  nebs_pkg::OP_QUERY, 8'd0,   32'hFFFF_FFFF, 1'b1, 8'd3},
			'{ROW_ITEM,  nebs_pkg::OP_QUERY, 8'd0,   32'h0000_0000, 1'b1, 8'd0},
			// table out of order: same steps, predictor decides
			'{ROW_ITEM,  nebs_pkg::OP_WRITE, 8'd2,   32'h0000_0500, 1'b0, 8'd0},
			'{ROW_ITEM,  nebs_pkg::OP_QUERY, 8'd0,   32'h0000_2800, 1'b0, 8'd0},
			'{ROW_ITEM,  nebs_pkg::OP_WRITE, 8'd255, 32'hFFFF_FFFF, 1'b0, 8'd0},
			// zero count searches one entry
			'{ROW_COUNT, nebs_pkg::OP_WRITE, 8'd0,   32'd0,         1'b0, 8'd0},
			'{ROW_ITEM,  nebs_pkg::OP_QUERY, 8'd0,   32'h0000_5000, 1'b1, 8'd0}
		};

		// Hold reset, then release it
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed rows
		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_COUNT)
				set_entry_count(dir_rows[r].freq[nebs_pkg::CNT_W-1:0]);
			else
				send_item(dir_rows[r].op, dir_rows[r].idx, dir_rows[r].freq,
					dir_rows[r].known, dir_rows[r].nearest);
		end

		// Full table with no idling on either side, then the saturated count
		quiet = 1'b1;
		run_phase(9'd256, 1'b1, 1'b0, 40);
		quiet = 1'b0;
		run_phase(9'd511, 1'b0, 1'b0, 30);

		// Mostly small well-formed tables, some noise
		phase = 0;
		while (item_total < 650) begin
			case (phase % 8)
				0: run_phase(9'd0, 1'b1, 1'b0, $urandom_range(30, 10));
				1: run_phase(9'd1, 1'b1, 1'b0, $urandom_range(30, 10));
				2: run_phase(9'd2, 1'b1, 1'b0, $urandom_range(30, 10));
				3: run_phase(9'($urandom_range(60, 25)), 1'b1, 1'b0, $urandom_range(30, 10));
				default: run_phase(9'($urandom_range(24, 3)), 1'b1,
					$urandom_range(5) == 0, $urandom_range(30, 10));
			endcase
			phase++;
		end

		wait_for_results();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("** nearest_entry_binary_search: PASSED **");
		else
			$display("** nearest_entry_binary_search: FAILED **");
		$finish;
	end

endmodule
